// ===== sv/clcd_pkg.sv =====
`default_nettype none
package clcd_pkg;

   // Operation codes
   localparam logic [2:0] OP_INIT       = 3'd0;
   localparam logic [2:0] OP_WRITE_CHAR = 3'd1;
   localparam logic [2:0] OP_WRITE_CMD  = 3'd2;
   localparam logic [2:0] OP_SET_CURSOR = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;

   // Expander bit positions and fixed values
   localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
   localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
   localparam logic [7:0] ENABLE_BIT    = 8'h04;
   localparam logic [7:0] SELECT_BIT    = 8'h01;
   localparam logic [7:0] ROW0_BASE     = 8'h80;
   localparam logic [7:0] ROW1_BASE     = 8'hC0;
   localparam logic [7:0] CLEAR_CMD     = 8'h01;
   localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
   localparam logic [3:0] FOURBIT_NIB   = 4'h2;

   // Waits in milliseconds
   localparam logic [5:0] WAIT_POWER_UP = 6'd50;
   localparam logic [2:0] WAIT_LONG     = 3'd5;
   localparam logic [2:0] WAIT_SHORT    = 3'd1;
   localparam logic [2:0] WAIT_CLEAR    = 3'd2;
   localparam logic [2:0] WAIT_NONE     = 3'd0;

   // Run lengths (last byte index)
   localparam logic [4:0] INIT_LAST_IDX = 5'd23;
   localparam logic [4:0] CMD_LAST_IDX  = 5'd3;
   localparam logic [4:0] INIT_CMD_BASE = 5'd8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_ok;
      logic at_last;
   } sts_type;

   // Command bytes sent after the wake-up pulses of init
   function automatic logic [7:0] init_cmd(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h28;
         2'd1:    val = 8'h0C;
         2'd2:    val = 8'h01;
         default: val = 8'h06;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ===== sv/clcd_ctrl.sv =====
`default_nettype none
module clcd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire clcd_pkg::sts_type sts,
   output logic                   busy,
   output clcd_pkg::cmd_type      cmd
);

   clcd_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         clcd_pkg::ST_IDLE: begin
            // unknown operations are taken and dropped
            if (start && sts.op_ok) begin
               cmd.load = 1'b1;
               state_in = clcd_pkg::ST_RUN;
            end
         end
         clcd_pkg::ST_RUN: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
            if (sts.at_last) begin
               state_in = clcd_pkg::ST_IDLE;
            end
         end
         default: state_in = clcd_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/clcd_dp.sv =====
`default_nettype none
module clcd_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clcd_pkg::cmd_type cmd,
   output clcd_pkg::sts_type      sts,
   input  wire logic [2:0]        req_operation,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_row,
   input  wire logic [5:0]        req_column,
   input  wire logic              csr_valid,
   input  wire logic [7:0]        csr_data,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_i2c_address,
   output logic [7:0]             rsp_expander_byte,
   output logic                   rsp_transfer_end,
   output logic [5:0]             rsp_wait_before_ms,
   output logic [2:0]             rsp_wait_after_ms,
   output logic                   rsp_last
);

   logic [7:0] addr_ff;
   logic [7:0] cmd_byte_ff, cmd_byte_in;
   logic       sel_ff, sel_in;
   logic       init_ff;
   logic [2:0] wait_cmd_ff, wait_cmd_in;
   logic [4:0] cnt_ff;

   logic       strobe_ff;
   logic [7:0] out_addr_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic [5:0] out_wb_ff, out_wb_in;
   logic [2:0] out_wa_ff, out_wa_in;
   logic       out_last_ff, out_last_in;

   logic [4:0] cmd_idx;
   logic [7:0] cur_cmd;
   logic [3:0] nib;
   logic       pulse_en;
   logic       cmd_end;
   logic       op_ok;
   logic       at_last;

   // Device address register, always writable
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 8'd78;
      end else if (csr_valid) begin
         addr_ff <= csr_data;
      end
   end

   // Decode the requested command at load time
   always_comb begin
      cmd_byte_in = req_data_byte;
      sel_in      = 1'b0;
      wait_cmd_in = clcd_pkg::WAIT_NONE;
      op_ok       = 1'b1;
      unique case (req_operation)
         clcd_pkg::OP_INIT: cmd_byte_in = '0;
         clcd_pkg::OP_WRITE_CHAR: sel_in = 1'b1;
         clcd_pkg::OP_WRITE_CMD: cmd_byte_in = req_data_byte;
         clcd_pkg::OP_SET_CURSOR:
            cmd_byte_in = (req_row ? clcd_pkg::ROW1_BASE : clcd_pkg::ROW0_BASE)
                          + {2'b00, req_column};
         clcd_pkg::OP_CLEAR: begin
            cmd_byte_in = clcd_pkg::CLEAR_CMD;
            wait_cmd_in = clcd_pkg::WAIT_CLEAR;
         end
         default: op_ok = 1'b0;
      endcase
   end

   // Item registers and byte counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_byte_ff <= cmd_byte_in;
         sel_ff      <= sel_in;
         init_ff     <= (req_operation == clcd_pkg::OP_INIT);
         wait_cmd_ff <= wait_cmd_in;
      end
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign at_last = init_ff ? (cnt_ff == clcd_pkg::INIT_LAST_IDX)
                            : (cnt_ff == clcd_pkg::CMD_LAST_IDX);

   // Status to the controller
   assign sts.op_ok   = op_ok;
   assign sts.at_last = at_last;

   // Byte generation: init runs 8 wake-up bytes then 4 commands
   assign cmd_idx  = init_ff ? (cnt_ff - clcd_pkg::INIT_CMD_BASE) : cnt_ff;
   assign cur_cmd  = init_ff ? clcd_pkg::init_cmd(cmd_idx[3:2]) : cmd_byte_ff;
   assign pulse_en = ~cnt_ff[0];
   assign cmd_end  = (cmd_idx[1:0] == 2'd3);

   always_comb begin
      out_wb_in   = '0;
      out_last_in = 1'b0;
      if (init_ff && cnt_ff < clcd_pkg::INIT_CMD_BASE) begin
         // wake-up pulses, one transfer each
         nib        = (cnt_ff[2:1] == 2'd3) ? clcd_pkg::FOURBIT_NIB
                                            : clcd_pkg::WAKE_NIBBLE;
         out_end_in = cnt_ff[0];
         out_wa_in  = !cnt_ff[0] ? clcd_pkg::WAIT_NONE :
                      (cnt_ff[2:1] == 2'd0) ? clcd_pkg::WAIT_LONG
                                            : clcd_pkg::WAIT_SHORT;
         if (cnt_ff == '0) begin
            out_wb_in = clcd_pkg::WAIT_POWER_UP;
         end
      end else begin
         nib        = cmd_idx[1] ? cur_cmd[3:0] : cur_cmd[7:4];
         out_end_in = cmd_end;
         if (!cmd_end) begin
            out_wa_in = clcd_pkg::WAIT_NONE;
         end else if (init_ff) begin
            out_wa_in = (cmd_idx[3:2] == 2'd2) ? clcd_pkg::WAIT_LONG
                                               : clcd_pkg::WAIT_SHORT;
         end else begin
            out_wa_in = wait_cmd_ff;
         end
         out_last_in = at_last;
      end
      out_byte_in = ({nib, 4'h0} & clcd_pkg::NIBBLE_MASK) | clcd_pkg::BACKLIGHT_BIT
                    | (pulse_en ? clcd_pkg::ENABLE_BIT : 8'h00)
                    | (sel_ff ? clcd_pkg::SELECT_BIT : 8'h00);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.step;
      end
      if (cmd.step) begin
         out_addr_ff <= addr_ff;
         out_byte_ff <= out_byte_in;
         out_end_ff  <= out_end_in;
         out_wb_ff   <= out_wb_in;
         out_wa_ff   <= out_wa_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_i2c_address    = out_addr_ff;
   assign rsp_expander_byte  = out_byte_ff;
   assign rsp_transfer_end   = out_end_ff;
   assign rsp_wait_before_ms = out_wb_ff;
   assign rsp_wait_after_ms  = out_wa_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/char_lcd_i2c_expander_sequencer.sv =====
// Character display sequencer for a 4-bit display behind an I2C port
// expander. Pulse start with a command while busy is low; the block then
// emits one expander byte per clock on the rsp_ ports, marked by rsp_strobe,
// which the receiver must take in that cycle (there is no way to stall it).
// Init yields 24 bytes, every other command 4; busy stays high while they
// are stepped out, as set by the byte counter that steps once per clock,
// and results appear in the cycle after busy. Unknown operation codes are
// accepted and dropped with no output. The device address is written over
// the csr_ channel (always ready) and should only change while idle.
`default_nettype none
module char_lcd_i2c_expander_sequencer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_row,
   input  wire logic [5:0] req_column,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_i2c_address,
   output logic [7:0]      rsp_expander_byte,
   output logic            rsp_transfer_end,
   output logic [5:0]      rsp_wait_before_ms,
   output logic [2:0]      rsp_wait_after_ms,
   output logic            rsp_last
);

   clcd_pkg::cmd_type cmd;
   clcd_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   clcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   clcd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .req_row            (req_row),
      .req_column         (req_column),
      .csr_valid          (csr_valid),
      .csr_data           (csr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_i2c_address    (rsp_i2c_address),
      .rsp_expander_byte  (rsp_expander_byte),
      .rsp_transfer_end   (rsp_transfer_end),
      .rsp_wait_before_ms (rsp_wait_before_ms),
      .rsp_wait_after_ms  (rsp_wait_after_ms),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

// ===== sv/clcd_chk.sv =====
`default_nettype none
module clcd_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_strobe,
   input wire logic [7:0] rsp_expander_byte,
   input wire logic       rsp_transfer_end,
   input wire logic [2:0] rsp_wait_after_ms,
   input wire logic       rsp_last
);

   // A run is gapless until its last byte
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a result run");

   // The last byte always closes a transfer
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_transfer_end)
      else $error("run ended mid transfer");

   // Waits after only on transfer ends
   a_wait_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_transfer_end |-> rsp_wait_after_ms == 3'd0)
      else $error("wait after on a non-final byte");

   // Enable is dropped on the closing byte of a transfer
   a_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_transfer_end |-> !rsp_expander_byte[2])
      else $error("transfer ended with enable high");

endmodule

bind char_lcd_i2c_expander_sequencer clcd_chk u_clcd_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_strobe        (rsp_strobe),
   .rsp_expander_byte (rsp_expander_byte),
   .rsp_transfer_end  (rsp_transfer_end),
   .rsp_wait_after_ms (rsp_wait_after_ms),
   .rsp_last          (rsp_last)
);
`default_nettype wire
